@@ hw/rtl/pcm_pkg.sv @@
// Package for the multi-mode PID controller: mode codes, operation codes,
// configuration register indexes and the mode bundle shared by front and back.
// No dependencies.
`default_nettype none
package pcm_pkg;

    typedef enum logic [1:0] {
        CTRL_POSITION    = 2'd0,
        CTRL_INCREMENTAL = 2'd1,
        CTRL_DISTANCE    = 2'd2,
        CTRL_HOLD        = 2'd3
    } ctrl_mode_t;

    typedef enum logic [1:0] {
        ERR_PLAIN   = 2'd0,
        ERR_GYRO    = 2'd1,
        ERR_ANGLE   = 2'd2,
        ERR_ENCODER = 2'd3
    } err_mode_t;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_RANGE  = 3'd7;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] ENCODER_RANGE_RESET = 16'd8192;

    typedef struct packed {
        ctrl_mode_t ctrl;
        err_mode_t  err;
    } mode_cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/pid_controller_multimode.sv @@
// Top level of the multi-mode PID controller: configuration registers,
// front end, queue and back end. Depends on pcm_pkg, pcm_front, pcm_queue, pcm_back.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    setpoint, feedback; tuser operation
//  m_        out        m_tvalid/m_tready    drive; tuser isat, osat
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; from acceptance
// an item goes via the queue and multiply stage to the accumulate stage output.
// Accumulate stage closes the integral/drive loop; one item a cycle if unstalled
// Synchronous active-low reset clears history, integral, drive and registers.
// An output stall backs up through the multiply stage into the two-entry queue.
`default_nettype none
module pid_controller_multimode
    import pcm_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // setpoint [W-1:0], feedback [2W-1:W], zero padding above
    input  wire logic [((2*WORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // operation
    input  wire logic                    s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // drive [W-1:0], zero padding above
    output logic [((WORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // integral_saturated [0], output_saturated [1]
    output logic [1:0]                   m_tuser,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [WORD_WIDTH-1:0]   cfg_data
);
    localparam int W  = WORD_WIDTH;
    localparam int IW = 3 * W + 1;
    localparam int OTW = ((W + 7) / 8) * 8;

    mode_cfg_t modes_reg;
    logic [W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [W-2:0] integral_limit_reg, output_limit_reg;
    logic [COUNT_W-1:0] encoder_range_reg;

    logic q_full, q_not_empty, push, pop, back_ready;
    logic [IW-1:0] front_item, q_head;
    logic [W-1:0] drive;
    logic isat, osat;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modes_reg          <= '{ctrl: CTRL_POSITION, err: ERR_PLAIN};
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            integral_limit_reg <= '0;
            output_limit_reg   <= '0;
            encoder_range_reg  <= ENCODER_RANGE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CONTROL_MODE:   modes_reg.ctrl     <= ctrl_mode_t'(cfg_data[1:0]);
                CFG_ERROR_MODE:     modes_reg.err      <= err_mode_t'(cfg_data[1:0]);
                CFG_GAIN_P:         gain_p_reg         <= cfg_data;
                CFG_GAIN_I:         gain_i_reg         <= cfg_data;
                CFG_GAIN_D:         gain_d_reg         <= cfg_data;
                CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[W-2:0];
                CFG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[W-2:0];
                CFG_ENCODER_RANGE:  encoder_range_reg  <= cfg_data[COUNT_W-1:0];
                default:            gain_p_reg         <= gain_p_reg;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;
    assign pop      = q_not_empty && back_ready;

    pcm_front #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .modes         (modes_reg),
        .encoder_range (encoder_range_reg),
        .push          (push),
        .operation     (s_tuser),
        .setpoint      (s_tdata[W-1:0]),
        .feedback      (s_tdata[2*W-1:W]),
        .item          (front_item)
    );

    pcm_queue #(.DATA_W(IW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_item),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    pcm_back #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .modes          (modes_reg),
        .gain_p         (gain_p_reg),
        .gain_i         (gain_i_reg),
        .gain_d         (gain_d_reg),
        .integral_limit (integral_limit_reg),
        .output_limit   (output_limit_reg),
        .in_valid       (q_not_empty),
        .in_item        (q_head),
        .in_ready       (back_ready),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_drive      (drive),
        .out_isat       (isat),
        .out_osat       (osat)
    );

    assign m_tdata = OTW'(drive);
    assign m_tuser = {osat, isat};

`ifndef SYNTHESIS
    a_osat_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && osat) |-> (drive == {1'b0, output_limit_reg}
                                || drive == -{1'b0, output_limit_reg}))
        else $error("output flag without drive at its limit");
    a_incr_no_isat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && modes_reg.ctrl == CTRL_INCREMENTAL) |-> !isat)
        else $error("integral flag in incremental mode");
    a_hold_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && modes_reg.ctrl == CTRL_HOLD) |-> (!isat && !osat))
        else $error("flag raised in hold mode");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/pcm_front.sv @@
// Front end: accepts items, forms the wrapped error and the gain operands,
// and keeps the error history. Depends on pcm_pkg.
`default_nettype none
module pcm_front
    import pcm_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire mode_cfg_t                 modes,
    input  wire logic [COUNT_W-1:0]        encoder_range,
    input  wire logic                      push,
    input  wire logic                      operation,
    input  wire logic [WORD_WIDTH-1:0]     setpoint,
    input  wire logic [WORD_WIDTH-1:0]     feedback,
    output logic [3*WORD_WIDTH:0]          item
);
    localparam int W  = WORD_WIDTH;
    localparam int XB = (W > FRAC_BITS + 19) ? W : FRAC_BITS + 19;
    localparam int XW = XB + 3;
    localparam int DW = COUNT_W + 3;

    localparam logic signed [XW-1:0] WMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
    localparam logic signed [XW-1:0] Q180   = XW'(180)  << FRAC_BITS;
    localparam logic signed [XW-1:0] Q360   = XW'(360)  << FRAC_BITS;
    localparam logic signed [XW-1:0] Q4096  = XW'(4096) << FRAC_BITS;
    localparam logic signed [XW-1:0] Q8191  = XW'(8191) << FRAC_BITS;

    function automatic logic [W-1:0] sat_x(input logic signed [XW-1:0] v);
        logic [W-1:0] r;
        if (v > WMAX_X) begin
            r = WMAX_X[W-1:0];
        end else if (v < WMIN_X) begin
            r = WMIN_X[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [XW-1:0] sx(input logic [W-1:0] v);
        return {{(XW-W){v[W-1]}}, v};
    endfunction

    logic [W-1:0] error_latest_reg, error_latest_next;
    logic [W-1:0] error_previous_reg, error_previous_next;

    logic signed [XW-1:0] el_x, raw_x, ang_x, dq_x, d1_x, d2_x, sp_x, fb_x;
    logic signed [DW-1:0] dc, half, rng;
    logic [W-1:0] e1, e, d1, d2, p_arg, d_arg;
    logic [COUNT_W-1:0] sp_cnt, fb_cnt;

    // Fold the stored latest error, form the new error and the differences
    always_comb begin
        el_x = sx(error_latest_reg);
        if (modes.err == ERR_GYRO) begin
            if (el_x > Q180) begin
                el_x = el_x - Q360;
            end else if (el_x < -Q180) begin
                el_x = el_x + Q360;
            end
        end
        e1 = sat_x(el_x);

        sp_x   = sx(setpoint);
        fb_x   = sx(feedback);
        sp_cnt = sp_x[FRAC_BITS+COUNT_W-1:FRAC_BITS];
        fb_cnt = fb_x[FRAC_BITS+COUNT_W-1:FRAC_BITS];
        rng    = DW'(encoder_range);
        half   = DW'(encoder_range[COUNT_W-1:1]);
        dc     = DW'(sp_cnt) - DW'(fb_cnt);
        if (dc > half) begin
            dc = dc - rng;
        end
        if (dc < -half) begin
            dc = dc + rng;
        end
        dq_x = {{(XW-DW){dc[DW-1]}}, dc} <<< FRAC_BITS;

        raw_x = sp_x - fb_x;
        ang_x = sx(sat_x(raw_x));
        if (ang_x > Q4096) begin
            ang_x = ang_x - Q8191;
        end else if (ang_x < -Q4096) begin
            ang_x = ang_x + Q8191;
        end

        case (modes.err)
            ERR_ENCODER: e = sat_x(dq_x);
            ERR_ANGLE:   e = sat_x(ang_x);
            default:     e = sat_x(raw_x);
        endcase

        d1_x = sx(e) - sx(e1);
        d2_x = sx(e) - (sx(e1) <<< 1) + sx(error_previous_reg);
        d1   = sat_x(d1_x);
        d2   = sat_x(d2_x);

        case (modes.ctrl)
            CTRL_POSITION: begin
                p_arg = e;
                d_arg = d1;
            end
            CTRL_INCREMENTAL: begin
                p_arg = d1;
                d_arg = d2;
            end
            default: begin
                p_arg = d1;
                d_arg = d1;
            end
        endcase

        item = {operation, e, p_arg, d_arg};

        error_latest_next   = error_latest_reg;
        error_previous_next = error_previous_reg;
        if (push) begin
            if (operation == OP_CLEAR) begin
                error_latest_next   = '0;
                error_previous_next = '0;
            end else begin
                error_latest_next   = e;
                error_previous_next = e1;
            end
        end
    end

    // Hold the error history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_latest_reg   <= '0;
            error_previous_reg <= '0;
        end else begin
            error_latest_reg   <= error_latest_next;
            error_previous_reg <= error_previous_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/pcm_queue.sv @@
// Two-entry queue between front and back end.
// Depends on nothing but its data width.
`default_nettype none
module pcm_queue #(
    parameter int DATA_W = 97
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic                   full,
    output logic                   not_empty,
    output logic [DATA_W-1:0]      head
);
    logic [DATA_W-1:0] slot_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    // Store the pushed transaction
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance the pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/pcm_back.sv @@
// Back end: three gain multiplies, then integral and drive update with clamps
// into the output register. Depends on pcm_pkg.
`default_nettype none
module pcm_back
    import pcm_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mode_cfg_t             modes,
    input  wire logic [WORD_WIDTH-1:0] gain_p,
    input  wire logic [WORD_WIDTH-1:0] gain_i,
    input  wire logic [WORD_WIDTH-1:0] gain_d,
    input  wire logic [WORD_WIDTH-2:0] integral_limit,
    input  wire logic [WORD_WIDTH-2:0] output_limit,
    input  wire logic                  in_valid,
    input  wire logic [3*WORD_WIDTH:0] in_item,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [WORD_WIDTH-1:0]      out_drive,
    output logic                       out_isat,
    output logic                       out_osat
);
    localparam int W  = WORD_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = W + 2;

    function automatic logic [W-1:0] sat_p(input logic signed [PW-1:0] v);
        logic [W-1:0] r;
        if (v > $signed({{(W+1){1'b0}}, {(W-1){1'b1}}})) begin
            r = {1'b0, {(W-1){1'b1}}};
        end else if (v < $signed({{(W+1){1'b1}}, {(W-1){1'b0}}})) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic [W-1:0] sat_s(input logic signed [SW-1:0] v);
        logic [W-1:0] r;
        if (v > $signed({3'b000, {(W-1){1'b1}}})) begin
            r = {1'b0, {(W-1){1'b1}}};
        end else if (v < $signed({3'b111, {(W-1){1'b0}}})) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    // Result is {flag, value}
    function automatic logic [W:0] clamp(input logic signed [W-1:0] v,
                                         input logic [W-2:0] lim);
        logic signed [W-1:0] l;
        logic [W:0] r;
        l = $signed({1'b0, lim});
        if (v > l) begin
            r = {1'b1, l};
        end else if (v < -l) begin
            r = {1'b1, -l};
        end else begin
            r = {1'b0, v};
        end
        return r;
    endfunction

    function automatic logic signed [SW-1:0] sx(input logic [W-1:0] v);
        return {{2{v[W-1]}}, v};
    endfunction

    logic s1_valid_reg, s1_op_reg;
    logic [W-1:0] p_reg, i_reg, d_reg;
    logic [W-1:0] integral_reg, integral_next, drive_reg, drive_next;
    logic [W-1:0] out_drive_reg, out_drive_next;
    logic out_valid_reg, out_isat_reg, out_isat_next, out_osat_reg, out_osat_next;
    logic s2_adv;
    logic [W:0] ic, oc;
    logic [W-1:0] isum;
    logic op_in;
    logic [W-1:0] e_in, pa_in, da_in;
    logic signed [PW-1:0] prod_p, prod_i, prod_d;

    assign {op_in, e_in, pa_in, da_in} = in_item;
    assign s2_adv    = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s2_adv;
    assign out_valid = out_valid_reg;
    assign out_drive = out_drive_reg;
    assign out_isat  = out_isat_reg;
    assign out_osat  = out_osat_reg;

    // Full products, floor-shifted by the fraction width
    always_comb begin
        prod_p = ($signed(gain_p) * $signed(pa_in)) >>> FRAC_BITS;
        prod_i = ($signed(gain_i) * $signed(e_in)) >>> FRAC_BITS;
        prod_d = ($signed(gain_d) * $signed(da_in)) >>> FRAC_BITS;
    end

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            s1_op_reg <= op_in;
            p_reg     <= sat_p(prod_p);
            i_reg     <= sat_p(prod_i);
            d_reg     <= sat_p(prod_d);
        end
    end

    // Accumulate, clamp and form the result
    always_comb begin
        integral_next  = integral_reg;
        drive_next     = drive_reg;
        out_isat_next  = 1'b0;
        out_osat_next  = 1'b0;
        ic   = '0;
        oc   = '0;
        isum = '0;
        if (s1_op_reg == OP_CLEAR) begin
            integral_next = '0;
            drive_next    = '0;
        end else begin
            case (modes.ctrl)
                CTRL_POSITION: begin
                    isum = sat_s(sx(integral_reg) + sx(i_reg));
                    ic   = clamp(isum, integral_limit);
                    oc   = clamp(sat_s(sx(p_reg) + sx(ic[W-1:0]) + sx(d_reg)),
                                 output_limit);
                    integral_next = ic[W-1:0];
                    drive_next    = oc[W-1:0];
                    out_isat_next = ic[W];
                    out_osat_next = oc[W];
                end
                CTRL_INCREMENTAL: begin
                    oc = clamp(sat_s(sx(drive_reg) + sx(p_reg) + sx(i_reg)
                                     + sx(d_reg)), output_limit);
                    integral_next = i_reg;
                    drive_next    = oc[W-1:0];
                    out_osat_next = oc[W];
                end
                CTRL_DISTANCE: begin
                    ic = clamp(i_reg, integral_limit);
                    oc = clamp(sat_s(sx(p_reg) + sx(ic[W-1:0]) + sx(d_reg)),
                               output_limit);
                    integral_next = ic[W-1:0];
                    drive_next    = oc[W-1:0];
                    out_isat_next = ic[W];
                    out_osat_next = oc[W];
                end
                default: begin
                    integral_next = integral_reg;
                end
            endcase
        end
        out_drive_next = drive_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            integral_reg  <= '0;
            drive_reg     <= '0;
        end else if (s2_adv) begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg) begin
                integral_reg <= integral_next;
                drive_reg    <= drive_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv && s1_valid_reg) begin
            out_drive_reg <= out_drive_next;
            out_isat_reg  <= out_isat_next;
            out_osat_reg  <= out_osat_next;
        end
    end

endmodule
`default_nettype wire
